FILE: hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

FILE: hdl/brn_pkg.sv
// Package: constants, types and helpers of the bilinear resize block.
package brn_pkg;
   localparam int MaxSrcWidth = 512;
   localparam int MaxSrcHeight = 512;
   localparam int MaxTargetSize = 512;
   localparam int XW = $clog2(MaxSrcWidth);
   localparam int YW = $clog2(MaxSrcHeight);
   localparam int AW = XW + YW;
   localparam int Depth = MaxSrcWidth * MaxSrcHeight;
   localparam int PixW = 24;
   // numerator of the coordinate division: pos*(dim-1) << 16
   localparam int NumW = 9 + 10 + 16;
   localparam int DivW = 10;

   localparam logic [2:0] CfgWidth = 3'd0;
   localparam logic [2:0] CfgHeight = 3'd1;
   localparam logic [2:0] CfgTarget = 3'd2;
   localparam logic [2:0] CfgOffsets = 3'd3;
   localparam logic [2:0] CfgGains = 3'd4;

   localparam logic CmdLoad = 1'b0;
   localparam logic CmdRequest = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DIVX, ST_DIVY, ST_ADDR, ST_RD, ST_MAC, ST_NORM, ST_DONE
   } state_type;
endpackage

FILE: hdl/brn_ram.sv
// Generic single-port RAM with registered read.
module brn_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wdata,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule

FILE: hdl/bilinear_resize_normalize.sv
// Top level: bilinear resize with per-channel mean/std normalization.
//
// Input channel req_*: one transfer either loads a source pixel (cmd 0) into
// the frame store at (col, row) or requests one destination pixel (cmd 1).
// Output channel rsp_*: one transfer per request carrying three Q4.11
// channels, the echoed position and the flags. Loads produce nothing.
// csr_*: write-only register port; write it only while the block is idle.
// Timing: loads stream back to back. A request in range raises rsp_tvalid
// after two 35-step restoring divisions (one quotient bit per cycle), an
// address state, frame-store reads of the four neighbours, then 8 steps
// per channel on one shared 27x21 signed multiplier. Out of range
// rsp_tvalid rises in the cycle after the transfer. The next request is
// accepted only once the result is taken; the divider loop and the single
// frame-store port bound the request rate.
// req_tready is low while a request is in work or a result waits.
// Reset clears control state and restores register defaults; the frame
// store is not cleared and holds garbage until written.
// A stalled receiver holds rsp_tvalid and the payload until it takes them.
module bilinear_resize_normalize
   import brn_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: col[8:0], row[17:9], red[25:18], green[33:26], blue[41:34], zero fill
   input  logic [47:0] req_tdata,
   // tuser: cmd
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: value_r, value_g, value_b, out_col, out_row, saturated, zero fill
   output logic [71:0] rsp_tdata,
   // tuser: range_error
   output logic        rsp_tuser,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [59:0] csr_wdata
);
`include "assert_macros.svh"

   logic [9:0]  w_ff, h_ff, t_ff;
   logic [47:0] off_ff;
   logic [59:0] gain_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff <= 10'd512; h_ff <= 10'd512; t_ff <= 10'd224;
         off_ff <= '0; gain_ff <= 60'd4521196125163536;
      end else if (csr_we) begin
         case (csr_index)
            CfgWidth:   w_ff <= csr_wdata[9:0];
            CfgHeight:  h_ff <= csr_wdata[9:0];
            CfgTarget:  t_ff <= csr_wdata[9:0];
            CfgOffsets: off_ff <= csr_wdata[47:0];
            CfgGains:   gain_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clamped dimensions
   logic [9:0] w_c, h_c, t_c, div_c;
   always_comb begin
      w_c = (w_ff == '0) ? 10'd1 : (w_ff > 10'(MaxSrcWidth)) ? 10'(MaxSrcWidth) : w_ff;
      h_c = (h_ff == '0) ? 10'd1 : (h_ff > 10'(MaxSrcHeight)) ? 10'(MaxSrcHeight) : h_ff;
      t_c = (t_ff > 10'(MaxTargetSize)) ? 10'(MaxTargetSize) : t_ff;
      div_c = (t_c > 10'd1) ? t_c - 10'd1 : 10'd1;
   end

   state_type state_ff, state_in;
   logic [8:0] col_ff, row_ff;
   logic [NumW-1:0] quo_ff, quo_in;      // division quotient / shifting numerator
   logic [DivW:0]   rem_ff, rem_in;
   logic [5:0]      cnt_ff, cnt_in;
   logic [NumW-1:0] px_ff, px_in;
   logic [AW-1:0]   addr;
   logic [PixW-1:0] rdata;
   logic            ram_we;
   logic [PixW-1:0] tex_ff [4];
   logic [YW-1:0]   y0_ff, y1_ff, y0_in, y1_in;
   logic [XW-1:0]   x0_ff, x1_ff, x0_in, x1_in;
   logic [16:0]     dx_ff, dy_ff, dx_in, dy_in;
   logic [47:0]     acc_ff, acc_in;     // running interpolation, Q8.16
   logic signed [42:0] diff_ff, diff_in;
   logic [1:0]      ch_ff, ch_in;
   logic [15:0]     val_ff [3];
   logic [15:0]     val_in;
   logic            sat_ff, sat_in, rerr_ff, rerr_in, rsp_v_ff, rsp_v_in;
   logic            val_we;

   logic [8:0] d_col, d_row;
   assign d_col = req_tdata[8:0];
   assign d_row = req_tdata[17:9];

   brn_ram #(.Width(PixW), .Depth(Depth)) u_store (
      .clock(clock), .we(ram_we), .addr(addr),
      .wdata(req_tdata[41:18]), .rdata(rdata)
   );

   // shared multiplier: 27-bit by 21-bit, both signed
   logic signed [26:0] mul_a;
   logic signed [20:0] mul_b;
   logic signed [47:0] mul_p;
   assign mul_p = mul_a * mul_b;

   // divider step
   logic [DivW:0] rem_sh;
   assign rem_sh = {rem_ff[DivW-1:0], quo_ff[NumW-1]};

   logic [7:0] t00, t01, t10, t11;
   logic [15:0] off_ch;
   logic [19:0] gain_ch;
   logic signed [63:0] qr;
   always_comb begin
      t00 = tex_ff[0][8*ch_ff +: 8];
      t01 = tex_ff[1][8*ch_ff +: 8];
      t10 = tex_ff[2][8*ch_ff +: 8];
      t11 = tex_ff[3][8*ch_ff +: 8];
      off_ch = off_ff[16*ch_ff +: 16];
      gain_ch = gain_ff[20*ch_ff +: 20];
   end

   always_comb begin
      state_in = state_ff;
      quo_in = quo_ff; rem_in = rem_ff; cnt_in = cnt_ff; px_in = px_ff;
      x0_in = x0_ff; x1_in = x1_ff; y0_in = y0_ff; y1_in = y1_ff;
      dx_in = dx_ff; dy_in = dy_ff; acc_in = acc_ff; diff_in = diff_ff;
      ch_in = ch_ff; sat_in = sat_ff; rerr_in = rerr_ff; rsp_v_in = rsp_v_ff;
      ram_we = 1'b0; addr = {d_row, d_col}; val_we = 1'b0; val_in = '0;
      mul_a = '0; mul_b = '0; qr = '0;
      req_tready = (state_ff == ST_IDLE) && !rsp_v_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               if (req_tuser == CmdLoad) begin
                  ram_we = 1'b1;
               end else if (d_col >= t_c || d_row >= t_c) begin
                  rerr_in = 1'b1; sat_in = 1'b0; rsp_v_in = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  rerr_in = 1'b0; sat_in = 1'b0;
                  quo_in = {NumW'(d_col * (w_c - 10'd1)) << 16};
                  rem_in = '0; cnt_in = 6'(NumW); state_in = ST_DIVX;
               end
            end
         end
         ST_DIVX, ST_DIVY: begin
            // restore step: one quotient bit per cycle
            if (rem_sh >= {1'b0, div_c}) begin
               rem_in = rem_sh - {1'b0, div_c};
               quo_in = {quo_ff[NumW-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[NumW-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               if (state_ff == ST_DIVX) begin
                  px_in = quo_in;
                  quo_in = {NumW'(row_ff * (h_c - 10'd1)) << 16};
                  rem_in = '0; cnt_in = 6'(NumW); state_in = ST_DIVY;
               end else begin
                  // clamp integer parts and fractions
                  if (px_ff[NumW-1:16] > NumW'(w_c - 10'd1) >> 0) begin
                     x0_in = XW'(w_c - 10'd1); dx_in = 17'hFFFF;
                  end else begin
                     x0_in = px_ff[16 +: XW]; dx_in = {1'b0, px_ff[15:0]};
                  end
                  if (quo_in[NumW-1:16] > NumW'(h_c - 10'd1)) begin
                     y0_in = YW'(h_c - 10'd1); dy_in = 17'hFFFF;
                  end else begin
                     y0_in = quo_in[16 +: YW]; dy_in = {1'b0, quo_in[15:0]};
                  end
                  x1_in = ({1'b0, x0_in} + 1'b1 < (XW+1)'(w_c)) ? x0_in + 1'b1
                          : XW'(w_c - 10'd1);
                  y1_in = ({1'b0, y0_in} + 1'b1 < (YW+1)'(h_c)) ? y0_in + 1'b1
                          : YW'(h_c - 10'd1);
                  cnt_in = '0; state_in = ST_ADDR;
               end
            end
         end
         ST_ADDR, ST_RD: begin
            // issue four reads, capture each in the cycle after its address
            case (cnt_ff[1:0])
               2'd0: addr = {y0_ff, x0_ff};
               2'd1: addr = {y0_ff, x1_ff};
               2'd2: addr = {y1_ff, x0_ff};
               default: addr = {y1_ff, x1_ff};
            endcase
            cnt_in = cnt_ff + 6'd1;
            state_in = ST_RD;
            if (cnt_ff == 6'd4) begin
               cnt_in = '0; ch_in = '0; state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            // steps per channel: 0 t00*(1-dx) 1 +t01*dx -> top, 2 *(1-dy),
            // 3 t10*(1-dx), 4 +t11*dx, 5 bot*dy added, offset subtracted
            case (cnt_ff[2:0])
               3'd0: begin
                  mul_a = 27'(t00); mul_b = 21'(17'h10000 - dx_ff);
                  acc_in = 48'(mul_p);
               end
               3'd1: begin
                  mul_a = 27'(t01); mul_b = 21'(dx_ff);
                  acc_in = acc_ff + 48'(mul_p);
               end
               3'd2: begin
                  mul_a = 27'(acc_ff[23:0]); mul_b = 21'(17'h10000 - dy_ff);
                  diff_in = 43'(mul_p);
                  acc_in = '0;
               end
               3'd3: begin
                  mul_a = 27'(t10); mul_b = 21'(17'h10000 - dx_ff);
                  acc_in = 48'(mul_p);
               end
               3'd4: begin
                  mul_a = 27'(t11); mul_b = 21'(dx_ff);
                  acc_in = acc_ff + 48'(mul_p);
               end
               default: begin
                  mul_a = 27'(acc_ff[23:0]); mul_b = 21'(dy_ff);
                  diff_in = diff_ff + 43'(mul_p) - 43'({off_ch, 24'd0});
               end
            endcase
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd5) begin
               cnt_in = '0; state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            // diff * gain split in two partial products on the shared unit
            if (cnt_ff == 6'd0) begin
               mul_a = {{5{diff_ff[42]}}, diff_ff[42:21]};
               mul_b = {1'b0, gain_ch};
               acc_in = 48'(mul_p);
               cnt_in = 6'd1;
            end else begin
               mul_a = {6'd0, diff_ff[20:0]};
               mul_b = {1'b0, gain_ch};
               qr = (64'($signed(acc_ff)) <<< 21) + 64'(mul_p) + (64'sd1 <<< 40);
               qr = qr >>> 41;
               if (qr > 64'sd32767) begin
                  val_in = 16'h7FFF; sat_in = 1'b1;
               end else if (qr < -64'sd32768) begin
                  val_in = 16'h8000; sat_in = 1'b1;
               end else begin
                  val_in = qr[15:0];
               end
               val_we = 1'b1;
               cnt_in = '0;
               if (ch_ff == 2'd2) begin
                  rsp_v_in = 1'b1; state_in = ST_DONE;
               end else begin
                  ch_in = ch_ff + 2'd1; state_in = ST_MAC;
               end
            end
         end
         ST_DONE: begin
            if (rsp_tready) begin
               rsp_v_in = 1'b0; state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in; rsp_v_ff <= rsp_v_in;
      end
      quo_ff <= quo_in; rem_ff <= rem_in; cnt_ff <= cnt_in; px_ff <= px_in;
      x0_ff <= x0_in; x1_ff <= x1_in; y0_ff <= y0_in; y1_ff <= y1_in;
      dx_ff <= dx_in; dy_ff <= dy_in; acc_ff <= acc_in; diff_ff <= diff_in;
      ch_ff <= ch_in; sat_ff <= sat_in; rerr_ff <= rerr_in;
      if (state_ff == ST_IDLE && req_tvalid && req_tready) begin
         col_ff <= d_col; row_ff <= d_row;
         val_ff[0] <= '0; val_ff[1] <= '0; val_ff[2] <= '0;
      end
      if (state_ff == ST_RD) begin
         tex_ff[cnt_ff[1:0] - 2'd1] <= rdata;
      end
      if (val_we) begin
         val_ff[ch_ff] <= val_in;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tuser = rerr_ff;
   assign rsp_tdata = {5'd0, sat_ff, row_ff, col_ff, val_ff[2], val_ff[1], val_ff[0]};

   `ASSERT_IMPL(a_busy_not_ready, clock, reset, state_ff != ST_IDLE, !req_tready,
      "ready while busy")
   `ASSERT_IMPL(a_rerr_no_sat, clock, reset, rsp_tvalid && rsp_tuser, !rsp_tdata[66],
      "saturation flagged on range error")
   `ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid,
      "result dropped while stalled")
endmodule
